// ----- src/i2d_pkg.sv -----
// Shared widths, character codes and types for the integer to decimal text converter.
`timescale 1ns / 1ps

package i2d_pkg;

    localparam int DATA_W     = 64;
    localparam int BCD_DIGITS = 20;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int CHAR_W     = 6;
    localparam int COUNT_W    = $clog2(DATA_W);
    localparam int NDIG_W     = $clog2(BCD_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

    typedef logic [3:0]       digit_t;
    typedef logic [BCD_W-1:0] bcd_t;

endpackage

// ----- src/int64_to_decimal_ascii.sv -----
// Top level: signed 64-bit integer to decimal ASCII text, one character per cycle while digits are emitted.
//
//   channel   direction  handshake              payload
//   command   in         start while !busy      value
//   result    out        valid (one cycle)      text_char, last
//
// A command is taken at a clock edge with start high and busy low; a minus sign, if
// any, leaves the cycle after. The shared shift-and-adjust unit takes one step per
// magnitude bit; the 20 - n leading zero slots of n digits drop one per cycle, then
// the first kept digit is found, and the n digits leave one per cycle. Busy stays
// high until the final character, which shows in the first idle cycle, when the next
// command can already be taken. Reset is asynchronous and active low and leaves the
// block idle. The receiver cannot stall.
`timescale 1ns / 1ps

module int64_to_decimal_ascii
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [63:0]            value,
    output logic                          valid,
    output logic [i2d_pkg::CHAR_W-1:0]    text_char,
    output logic                          last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]                        state_reg, state_next;
    logic                              valid_reg, valid_next;
    logic [i2d_pkg::DATA_W-1:0]        mag_reg, mag_next;
    i2d_pkg::bcd_t                     bcd_reg, bcd_next;
    logic [i2d_pkg::COUNT_W-1:0]       cnt_reg, cnt_next;
    logic [i2d_pkg::NDIG_W-1:0]        ndig_reg, ndig_next;
    logic [i2d_pkg::CHAR_W-1:0]        char_reg, char_next;
    logic                              last_reg, last_next;

    i2d_pkg::bcd_t                     step_out;
    i2d_pkg::digit_t                   top_digit;
    logic                              accept;

    assign accept    = start && (state_reg == ST_IDLE);
    assign top_digit = bcd_reg[i2d_pkg::BCD_W-1 -: 4];

    // Shared shift-and-adjust unit
    i2d_bcd_step u_step
    (
        .bcd_in  (bcd_reg),
        .bit_in  (mag_reg[i2d_pkg::DATA_W-1]),
        .bcd_out (step_out)
    );

    // Sequence conversion, zero skip and emission
    always_comb
    begin
        state_next = state_reg;
        valid_next = 1'b0;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        ndig_next  = ndig_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mag_next   = value[i2d_pkg::DATA_W-1] ? (64'd0 - value) : value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    // Emit the minus sign right away
                    valid_next = value[i2d_pkg::DATA_W-1];
                    char_next  = i2d_pkg::CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = step_out;
                mag_next = {mag_reg[i2d_pkg::DATA_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == i2d_pkg::COUNT_W'(i2d_pkg::DATA_W - 1))
                begin
                    ndig_next  = i2d_pkg::NDIG_W'(i2d_pkg::BCD_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Drop leading zero digits, keep at least one
                if ((top_digit == 4'd0) && (ndig_reg != i2d_pkg::NDIG_W'(1)))
                begin
                    bcd_next  = {bcd_reg[i2d_pkg::BCD_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                valid_next = 1'b1;
                char_next  = i2d_pkg::CHAR_ZERO + {2'b00, top_digit};
                last_next  = (ndig_reg == i2d_pkg::NDIG_W'(1));
                bcd_next   = {bcd_reg[i2d_pkg::BCD_W-5:0], 4'd0};
                ndig_next  = ndig_reg - 1'b1;
                if (ndig_reg == i2d_pkg::NDIG_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        ndig_reg <= ndig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign valid     = valid_reg;
    assign text_char = char_reg;
    assign last      = last_reg;

endmodule

// ----- src/i2d_bcd_step.sv -----
// One shift-and-adjust step of binary to BCD conversion over all BCD digits.
`timescale 1ns / 1ps

module i2d_bcd_step
(
    input  i2d_pkg::bcd_t bcd_in,
    input  logic          bit_in,
    output i2d_pkg::bcd_t bcd_out
);

    i2d_pkg::bcd_t adj;

    // Add three to every digit of five or more, each digit on its own
    always_comb
    begin
        for (int i = 0; i < i2d_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_in[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = bcd_in[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adj[i*4 +: 4] = bcd_in[i*4 +: 4];
            end
        end
    end

    // Shift the next binary bit in at the bottom
    assign bcd_out = {adj[i2d_pkg::BCD_W-2:0], bit_in};

endmodule

// ----- src/i2d_chk.sv -----
// Port-level checker for the integer to decimal text converter, with its bind.
`timescale 1ns / 1ps

module i2d_chk
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       valid,
    input logic [i2d_pkg::CHAR_W-1:0] text_char,
    input logic                       last
);

    // An accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // Busy drops exactly when the final character leaves
    a_fell_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (valid && last))
        else $error("busy dropped without final character");

    // A character that is not final comes while still busy
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !last) |-> busy)
        else $error("non-final character while idle");

    // Only minus or a decimal digit appears
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> ((text_char == i2d_pkg::CHAR_MINUS) ||
                   ((text_char >= i2d_pkg::CHAR_ZERO) &&
                    (text_char <= i2d_pkg::CHAR_NINE))))
        else $error("illegal character code");

    // A minus sign is never the final character
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (text_char == i2d_pkg::CHAR_MINUS)) |-> !last)
        else $error("minus sign marked final");

endmodule

bind int64_to_decimal_ascii i2d_chk u_i2d_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .valid     (valid),
    .text_char (text_char),
    .last      (last)
);
